### hdl/mrq_pkg.sv
// shared types and codes for the message ring queue
package mrq_pkg;

  localparam int unsigned DEPTH_DEF    = 16;
  localparam int unsigned MSG_BITS_DEF = 32;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CNT_W   = 5;

  localparam logic [KIND_W-1:0] KIND_BACK      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FRONT     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OVERWRITE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RECEIVE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PEEK      = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] message_in;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] message_out;
    logic [CNT_W-1:0]  fill_level;
  } out_t;

endpackage

### hdl/mrq_ram.sv
// generic single write port ram with registered read
module mrq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds when no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/message_ring_queue_core.sv
// message ring queue: circular fifo with front/back send, overwrite, receive and peek
//
// usage:
//   in channel (in_valid_i/in_ready_o, in_i) carries one request: kind and message.
//   out channel (out_valid_o/out_ready_i, out_o) returns one result per request:
//   status, oldest message on receive or peek, and fill level after the request.
//   cfg channel (cfg_valid_i/cfg_ready_o, cfg_data_i) writes the capacity; a write
//   clamps the value to 1..min(DEPTH, 31) and clears pointers and count. write it
//   only while no request is in flight.
// result: valid in the cycle after its request transfer.
// throughput: one request per cycle unless stalled; the pointer and count update
//   and the storage access of one request finish in the cycle of its transfer, and
//   the message read out of the storage ram lands in the result stage next cycle.
// stall: the result stage holds while out_ready_i is low; a new request is taken
//   in the same cycle the waiting result transfers.
// reset: pointers and count clear, capacity returns to min(DEPTH, 16); storage
//   contents are not cleared and are only read after being written.
module message_ring_queue_core #(
  parameter int unsigned DEPTH    = mrq_pkg::DEPTH_DEF,
  parameter int unsigned MSG_BITS = mrq_pkg::MSG_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mrq_pkg::in_t                  in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mrq_pkg::out_t                 out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mrq_pkg::CNT_W-1:0]     cfg_data_i
);

  localparam int unsigned CW      = mrq_pkg::CNT_W;
  localparam int unsigned CNT_MAX = (1 << CW) - 1;
  localparam int unsigned CAP_MAX = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;
  localparam int unsigned CAP_RST = (DEPTH < 16) ? DEPTH : 16;
  localparam int unsigned PW      = (CAP_MAX > 1) ? $clog2(CAP_MAX) : 1;
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CW-1:0] cap_q;
  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;

  logic                        s1_valid_q;
  logic                        s1_rd_q;
  logic [mrq_pkg::STAT_W-1:0]  s1_status_q;
  logic [CW-1:0]               s1_fill_q;

  logic                        accept;
  logic                        full, empty;
  logic                        we, re;
  logic [PW-1:0]               waddr;
  logic [mrq_pkg::STAT_W-1:0]  status;
  logic [MSG_BITS-1:0]         wdata;
  logic [MSG_BITS-1:0]         rdata;
  logic [CW-1:0]               cap_new;

  function automatic logic [PW-1:0] next_ptr(logic [PW-1:0] i, logic [CW-1:0] cap);
    logic [CW-1:0] inc;
    inc = CW'(i) + 1'b1;
    return (inc >= cap) ? '0 : PW'(inc);
  endfunction

  function automatic logic [PW-1:0] prev_ptr(logic [PW-1:0] i, logic [CW-1:0] cap);
    return (i == '0) ? PW'(cap - 1'b1) : i - 1'b1;
  endfunction

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = !s1_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign full        = count_q >= cap_q;
  assign empty       = count_q == '0;
  assign wdata       = MSG_BITS'(in_i.message_in);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = tail_q;
    status  = mrq_pkg::ST_OK;
    case (in_i.kind) inside
      mrq_pkg::KIND_BACK, mrq_pkg::KIND_FRONT, mrq_pkg::KIND_OVERWRITE: begin
        if (full && in_i.kind != mrq_pkg::KIND_OVERWRITE) begin
          status = mrq_pkg::ST_FULL;
        end else if (empty || in_i.kind == mrq_pkg::KIND_BACK) begin
          we      = 1'b1;
          waddr   = tail_q;
          tail_d  = next_ptr(tail_q, cap_q);
          count_d = count_q + 1'b1;
        end else if (in_i.kind == mrq_pkg::KIND_OVERWRITE) begin
          we    = 1'b1;
          waddr = head_q;
        end else begin
          // send to front: step head back, store there
          we      = 1'b1;
          waddr   = prev_ptr(head_q, cap_q);
          head_d  = prev_ptr(head_q, cap_q);
          count_d = count_q + 1'b1;
        end
      end
      mrq_pkg::KIND_RECEIVE, mrq_pkg::KIND_PEEK: begin
        if (empty) begin
          status = mrq_pkg::ST_EMPTY;
        end else begin
          re = 1'b1;
          if (in_i.kind == mrq_pkg::KIND_RECEIVE) begin
            head_d  = next_ptr(head_q, cap_q);
            count_d = count_q - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // clamp capacity into 1..min(DEPTH, counter range)
  always_comb begin
    cap_new = cfg_data_i;
    if (cap_new == '0) begin
      cap_new = CW'(1);
    end else if (cap_new > CW'(CAP_MAX)) begin
      cap_new = CW'(CAP_MAX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= CW'(CAP_RST);
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q   <= cap_new;
        head_q  <= '0;
        tail_q  <= '0;
        count_q <= '0;
      end else if (accept) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rd_q     <= re;
      s1_status_q <= status;
      s1_fill_q   <= count_d;
    end
  end

  mrq_ram #(
    .WIDTH (MSG_BITS),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (accept && we),
    .waddr_i (AW'(waddr)),
    .wdata_i (wdata),
    .re_i    (accept && re),
    .raddr_i (AW'(head_q)),
    .rdata_o (rdata)
  );

  assign out_valid_o       = s1_valid_q;
  assign out_o.status      = s1_status_q;
  assign out_o.message_out = s1_rd_q ? mrq_pkg::DATA_W'(rdata) : '0;
  assign out_o.fill_level  = s1_fill_q;

  a_count_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("stored count above capacity");

  a_ptrs_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW'(head_q) < cap_q) && (CW'(tail_q) < cap_q))
    else $error("pointer outside capacity");

  a_empty_ptrs_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("empty queue with split pointers");

  a_read_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_rd_q) |-> (s1_status_q == mrq_pkg::ST_OK))
    else $error("message read with failing status");

endmodule
